/* hdl/redp_pkg.sv */
package redp_pkg;

  localparam int OPND_W  = 16;
  localparam int VAL_W   = 64;
  localparam int START_W = 4;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_ZERO = 2'd3
  } op_t;

  typedef struct packed {
    logic       ld_we;
    logic       init_we;
    logic       tbl_we;
    logic       alu_start;
    logic [1:0] combo;
    logic       best_upd;
    logic       best_first;
    logic       fin_cmp;
    logic       fin_first;
    logic       emit;
  } cmd_t;

endpackage

/* hdl/redp_item_if.sv */
interface redp_item_if;
  import redp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OPND_W-1:0] operand_value;
  logic [1:0]               op_to_next;
  logic                     is_last;

  modport source (output valid, operand_value, op_to_next, is_last, input ready);
  modport sink (input valid, operand_value, op_to_next, is_last, output ready);
endinterface

/* hdl/redp_result_if.sv */
interface redp_result_if;
  import redp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] min_result;
  logic signed [VAL_W-1:0] max_result;
  logic [START_W-1:0]      min_start;
  logic [START_W-1:0]      max_start;
  logic                    overflow;

  modport source (output valid, min_result, max_result, min_start, max_start, overflow,
                  input ready);
  modport sink (input valid, min_result, max_result, min_start, max_start, overflow,
                output ready);
endinterface

/* hdl/redp_alu.sv */
module redp_alu import redp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] a,
  input  logic signed [VAL_W-1:0] b,
  input  op_t                     op,
  output logic                    done,
  output logic signed [VAL_W-1:0] y
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_SAT} astate_t;

  astate_t            st;
  logic [2:0]         cnt;
  logic [VAL_W-1:0]   ua;
  logic [VAL_W-1:0]   ub;
  logic               neg;
  logic [VAL_W-1:0]   pp;
  logic [2*VAL_W-1:0] acc;
  logic [VAL_W:0]     sum;
  logic [VAL_W:0]     dif;
  logic [VAL_W-1:0]   prod;
  logic [2*VAL_W-1:0] pp_sh;
  logic               big_neg;
  logic               big_pos;

  assign sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
  assign dif = {a[VAL_W-1], a} - {b[VAL_W-1], b};

  always_comb begin
    case (cnt[1:0])
      2'd0:    prod = ua[31:0] * ub[31:0];
      2'd1:    prod = ua[31:0] * ub[63:32];
      2'd2:    prod = ua[63:32] * ub[31:0];
      default: prod = ua[63:32] * ub[63:32];
    endcase
  end

  always_comb begin
    case (cnt)
      3'd1:         pp_sh = {64'd0, pp};
      3'd2, 3'd3:   pp_sh = {32'd0, pp, 32'd0};
      3'd4:         pp_sh = {pp, 64'd0};
      default:      pp_sh = '0;
    endcase
  end

  assign big_pos = acc[2*VAL_W-1:VAL_W-1] != '0;
  assign big_neg = (acc[2*VAL_W-1:VAL_W] != '0) || (acc[VAL_W-1] && acc[VAL_W-2:0] != '0);

  function automatic logic signed [VAL_W-1:0] sat65(input logic [VAL_W:0] s);
    if (s[VAL_W] != s[VAL_W-1]) begin
      return s[VAL_W] ? VAL_MIN : VAL_MAX;
    end
    return s[VAL_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (start) begin
            case (op)
              OP_ADD: begin
                y    <= sat65(sum);
                done <= 1'b1;
              end
              OP_SUB: begin
                y    <= sat65(dif);
                done <= 1'b1;
              end
              OP_MUL: begin
                ua  <= a[VAL_W-1] ? (~a + 1'b1) : a;
                ub  <= b[VAL_W-1] ? (~b + 1'b1) : b;
                neg <= a[VAL_W-1] ^ b[VAL_W-1];
                acc <= '0;
                cnt <= '0;
                st  <= A_MUL;
              end
              default: begin
                y    <= '0;
                done <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          pp  <= prod;
          acc <= acc + pp_sh;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) begin
            st <= A_SAT;
          end
        end
        A_SAT: begin
          if (neg) begin
            y <= big_neg ? VAL_MIN : (~acc[VAL_W-1:0] + 1'b1);
          end else begin
            y <= big_pos ? VAL_MAX : acc[VAL_W-1:0];
          end
          done <= 1'b1;
          st   <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

/* hdl/redp_dp.sv */
module redp_dp import redp_pkg::*; #(
  parameter int MAX_ELEMS = 16,
  parameter int IW        = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cmd_t                     cmd,
  input  logic [IW-1:0]            ld_addr,
  input  logic [IW-1:0]            pos_addr,
  input  logic [IW-1:0]            op_addr,
  input  logic [2*IW-1:0]          ra,
  input  logic [2*IW-1:0]          rb,
  input  logic [2*IW-1:0]          wa,
  input  logic [IW-1:0]            fin_s,
  input  logic                     ovf,
  input  logic signed [OPND_W-1:0] operand_value,
  input  logic [1:0]               op_to_next,
  output logic                     alu_done,
  output logic signed [VAL_W-1:0]  min_result,
  output logic signed [VAL_W-1:0]  max_result,
  output logic [START_W-1:0]       min_start,
  output logic [START_W-1:0]       max_start,
  output logic                     overflow
);

  localparam int TD = 1 << (2 * IW);

  logic signed [OPND_W-1:0] opnd_mem [MAX_ELEMS];
  logic [1:0]               oper_mem [MAX_ELEMS];
  logic signed [VAL_W-1:0]  tmin [TD];
  logic signed [VAL_W-1:0]  tmax [TD];

  logic signed [OPND_W-1:0] opnd_q;
  logic [1:0]               oper_q;
  logic signed [VAL_W-1:0]  min_a, max_a, min_b, max_b;
  logic signed [VAL_W-1:0]  best_lo, best_hi;
  logic signed [VAL_W-1:0]  mn, mx;
  logic [IW-1:0]            mn_s, mx_s;
  logic signed [VAL_W-1:0]  alu_a, alu_b, alu_y;
  logic signed [VAL_W-1:0]  wr_lo, wr_hi;

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      opnd_mem[ld_addr] <= operand_value;
      oper_mem[ld_addr] <= op_to_next;
    end
    opnd_q <= opnd_mem[pos_addr];
    oper_q <= oper_mem[op_addr];
  end

  assign wr_lo = cmd.init_we ? VAL_W'(opnd_q) : best_lo;
  assign wr_hi = cmd.init_we ? VAL_W'(opnd_q) : best_hi;

  always_ff @(posedge clk) begin
    if (cmd.init_we || cmd.tbl_we) begin
      tmin[wa] <= wr_lo;
      tmax[wa] <= wr_hi;
    end
    min_a <= tmin[ra];
    max_a <= tmax[ra];
    min_b <= tmin[rb];
    max_b <= tmax[rb];
  end

  assign alu_a = cmd.combo[1] ? max_a : min_a;
  assign alu_b = cmd.combo[0] ? max_b : min_b;

  redp_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.alu_start),
    .a     (alu_a),
    .b     (alu_b),
    .op    (op_t'(oper_q)),
    .done  (alu_done),
    .y     (alu_y)
  );

  always_ff @(posedge clk) begin
    if (cmd.best_upd) begin
      if (cmd.best_first || alu_y < best_lo) best_lo <= alu_y;
      if (cmd.best_first || alu_y > best_hi) best_hi <= alu_y;
    end
    if (cmd.fin_cmp) begin
      if (cmd.fin_first || min_a < mn) begin
        mn   <= min_a;
        mn_s <= fin_s;
      end
      if (cmd.fin_first || max_a > mx) begin
        mx   <= max_a;
        mx_s <= fin_s;
      end
    end
    if (cmd.emit) begin
      min_result <= mn;
      max_result <= mx;
      min_start  <= START_W'(mn_s);
      max_start  <= START_W'(mx_s);
      overflow   <= ovf;
    end
  end

endmodule

/* hdl/redp_ctrl.sv */
module redp_ctrl import redp_pkg::*; #(
  parameter int MAX_ELEMS = 16,
  parameter int IW        = 4,
  parameter int CW        = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  logic            alu_done,
  output cmd_t            cmd,
  output logic [IW-1:0]   ld_addr,
  output logic [IW-1:0]   pos_addr,
  output logic [IW-1:0]   op_addr,
  output logic [2*IW-1:0] ra,
  output logic [2*IW-1:0] rb,
  output logic [2*IW-1:0] wa,
  output logic [IW-1:0]   fin_s,
  output logic            ovf
);

  typedef enum logic [3:0] {
    LOAD, INIT_RD, INIT_WR, SPL_RD, ALU_GO, ALU_WAIT, TBL_WR, FIN_RD, FIN_CMP, EMIT
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [IW-1:0] s;
  logic [IW-1:0] i;
  logic [CW-1:0] len;
  logic [1:0]    k;

  logic [IW:0]   s2_raw, op_raw, n_ext;
  logic [IW-1:0] s2, opi, n_m1, len_m1, r_len;
  logic          accept, emit_ok, last_s, last_i;

  assign accept  = in_valid && in_ready;
  assign emit_ok = (state == EMIT) && (!out_valid || out_ready);
  assign n_ext   = (IW+1)'(count);
  assign s2_raw  = {1'b0, s} + {1'b0, i};
  assign op_raw  = s2_raw - (IW+1)'(1);
  assign s2      = (s2_raw >= n_ext) ? IW'(s2_raw - n_ext) : IW'(s2_raw);
  assign opi     = (op_raw >= n_ext) ? IW'(op_raw - n_ext) : IW'(op_raw);
  assign n_m1    = IW'(count - CW'(1));
  assign len_m1  = IW'(len - CW'(1));
  assign r_len   = IW'(len - CW'(i) - CW'(1));
  assign last_s  = s == n_m1;
  assign last_i  = i == len_m1;

  assign in_ready = state == LOAD;
  assign ld_addr  = IW'(count);
  assign pos_addr = s;
  assign op_addr  = opi;
  assign ra       = (state == FIN_RD) ? {s, n_m1} : {s, i - IW'(1)};
  assign rb       = {s2, r_len};
  assign wa       = (state == TBL_WR) ? {s, len_m1} : {s, IW'(0)};
  assign fin_s    = s;

  always_comb begin
    cmd            = '0;
    cmd.ld_we      = accept && (count < CW'(MAX_ELEMS));
    cmd.init_we    = state == INIT_WR;
    cmd.tbl_we     = state == TBL_WR;
    cmd.alu_start  = state == ALU_GO;
    cmd.combo      = k;
    cmd.best_upd   = (state == ALU_WAIT) && alu_done;
    cmd.best_first = (i == IW'(1)) && (k == 2'd0);
    cmd.fin_cmp    = state == FIN_CMP;
    cmd.fin_first  = s == '0;
    cmd.emit       = emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      s         <= '0;
      i         <= '0;
      len       <= '0;
      k         <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        LOAD: begin
          if (accept) begin
            if (count < CW'(MAX_ELEMS)) count <= count + CW'(1);
            else ovf <= 1'b1;
            if (in_last) begin
              s     <= '0;
              state <= INIT_RD;
            end
          end
        end
        INIT_RD: state <= INIT_WR;
        INIT_WR: begin
          if (last_s) begin
            s   <= '0;
            i   <= IW'(1);
            k   <= '0;
            len <= CW'(2);
            state <= (count == CW'(1)) ? FIN_RD : SPL_RD;
          end else begin
            s     <= s + IW'(1);
            state <= INIT_RD;
          end
        end
        SPL_RD: state <= ALU_GO;
        ALU_GO: state <= ALU_WAIT;
        ALU_WAIT: begin
          if (alu_done) begin
            k <= k + 2'd1;
            if (k != 2'd3) state <= ALU_GO;
            else if (last_i) state <= TBL_WR;
            else begin
              i     <= i + IW'(1);
              state <= SPL_RD;
            end
          end
        end
        TBL_WR: begin
          i <= IW'(1);
          k <= '0;
          if (last_s) begin
            s <= '0;
            if (len == count) state <= FIN_RD;
            else begin
              len   <= len + CW'(1);
              state <= SPL_RD;
            end
          end else begin
            s     <= s + IW'(1);
            state <= SPL_RD;
          end
        end
        FIN_RD: state <= FIN_CMP;
        FIN_CMP: begin
          if (last_s) state <= EMIT;
          else begin
            s     <= s + IW'(1);
            state <= FIN_RD;
          end
        end
        EMIT: begin
          if (emit_ok) begin
            out_valid <= 1'b1;
            count     <= '0;
            ovf       <= 1'b0;
            state     <= LOAD;
          end
        end
        default: state <= LOAD;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ELEMS)) else $error("operand count past capacity");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == ALU_WAIT) else $error("alu result outside wait");
  a_ring_nonempty: assert property (@(posedge clk) disable iff (rst)
    state != LOAD |-> count != '0) else $error("compute with empty ring");
  a_emit_clear: assert property (@(posedge clk) disable iff (rst)
    emit_ok |=> out_valid && count == '0 && !ovf) else $error("emit did not clear ring");

endmodule

/* hdl/ring_expression_minmax_dp.sv */
// Ring expression min/max evaluator.
// item channel: one beat per ring operand with its operator to the next operand;
//   is_last closes the ring and starts the evaluation. Beats are taken one per
//   cycle while loading; beats past MAX_ELEMS are dropped and flag overflow.
// result channel: one beat per ring with the min and max over all
//   parenthesizations and start positions, the first start of each, and overflow.
// After the last beat the evaluator seeds the interval tables, then for every
//   length and start does one table write plus, per split, one table read and
//   four operator evaluations (multiply from 32x32 partial products), then
//   scans the full rings and loads the result register.
// item.ready is high only while loading; the next ring may load while the
//   result beat still waits. If the receiver stalls, the next result waits in
//   the evaluator until the result register frees.
// Reset (rst, synchronous) empties the ring and drops any pending result.
module ring_expression_minmax_dp import redp_pkg::*; #(
  parameter int MAX_ELEMS = 16
) (
  input logic           clk,
  input logic           rst,
  redp_item_if.sink     item,
  redp_result_if.source result
);

  localparam int IW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);

  cmd_t            cmd;
  logic            alu_done;
  logic            ovf;
  logic [IW-1:0]   ld_addr, pos_addr, op_addr, fin_s;
  logic [2*IW-1:0] ra, rb, wa;

  redp_ctrl #(.MAX_ELEMS(MAX_ELEMS), .IW(IW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_last   (item.is_last),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .alu_done  (alu_done),
    .cmd       (cmd),
    .ld_addr   (ld_addr),
    .pos_addr  (pos_addr),
    .op_addr   (op_addr),
    .ra        (ra),
    .rb        (rb),
    .wa        (wa),
    .fin_s     (fin_s),
    .ovf       (ovf)
  );

  redp_dp #(.MAX_ELEMS(MAX_ELEMS), .IW(IW)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .ld_addr       (ld_addr),
    .pos_addr      (pos_addr),
    .op_addr       (op_addr),
    .ra            (ra),
    .rb            (rb),
    .wa            (wa),
    .fin_s         (fin_s),
    .ovf           (ovf),
    .operand_value (item.operand_value),
    .op_to_next    (item.op_to_next),
    .alu_done      (alu_done),
    .min_result    (result.min_result),
    .max_result    (result.max_result),
    .min_start     (result.min_start),
    .max_start     (result.max_start),
    .overflow      (result.overflow)
  );

endmodule
